// ===== design/record_frame_parser_defines.svh =====
// Assertion macros shared by the record frame parser modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RECORD_FRAME_PARSER_DEFINES_SVH
`define RECORD_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rfp assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define RFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rfp assertion failed: next-cycle implication");

`endif

// ===== design/rfp_pkg.sv =====
// Types and constants for the record frame parser.
// No dependencies; imported by every module of the block.
package rfp_pkg;

  localparam logic [4:0] MIN_FRAME_BYTES = 5'(1 + 8 + 4 + 4);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAPSHOT_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_CODE    = 1'b1;

  localparam logic [7:0] SNAPSHOT_CODE_RESET = 8'd0;
  localparam logic [7:0] DELTA_CODE_RESET    = 8'd1;

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_TIME   = 3'd1,
    PH_KLEN   = 3'd2,
    PH_KEY    = 3'd3,
    PH_PLEN   = 3'd4,
    PH_PAY    = 3'd5,
    PH_EXCESS = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TRUNCATED   = 3'd1,
    ST_BAD_TYPE    = 3'd2,
    ST_BAD_KEY_LEN = 3'd3,
    ST_BAD_PAYLOAD = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  byte_role;
    logic        frame_done;
    logic [2:0]  frame_status;
    logic [63:0] timestamp_value;
  } out_item_t;

endpackage

// ===== design/rfp_frame.sv =====
// Frame tracker: per-byte role tagging, length counters and end-of-frame status.
// Depends on rfp_pkg and record_frame_parser_defines.svh.
`include "record_frame_parser_defines.svh"

module rfp_frame
  import rfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  in_item_t             item,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output out_item_t            result_next
);

  logic [7:0]  snapshot_code;
  logic [7:0]  delta_code;

  phase_t      phase;
  logic [3:0]  field_count;
  logic [4:0]  total_count;
  logic [31:0] key_remaining;
  logic [31:0] payload_remaining;
  logic [63:0] timestamp_shift;
  logic        type_bad;
  logic        excess_seen;

  // values after this byte, before end-of-frame clearing
  phase_t      phase_upd;
  logic [3:0]  field_count_upd;
  logic [4:0]  total_count_upd;
  logic [31:0] key_upd;
  logic [31:0] payload_upd;
  logic [63:0] timestamp_upd;
  logic        type_bad_upd;
  logic        excess_upd;

  logic [31:0] key_shifted;
  logic [31:0] payload_shifted;
  logic [31:0] key_dec;
  logic [31:0] payload_dec;
  status_t     status;

  assign key_shifted     = {key_remaining[23:0], item.data_byte};
  assign payload_shifted = {payload_remaining[23:0], item.data_byte};
  assign key_dec         = key_remaining - 32'd1;
  assign payload_dec     = payload_remaining - 32'd1;

  // next state
  always_comb begin
    phase_upd       = phase;
    field_count_upd = field_count;
    key_upd         = key_remaining;
    payload_upd     = payload_remaining;
    timestamp_upd   = timestamp_shift;
    type_bad_upd    = type_bad;
    excess_upd      = excess_seen;
    total_count_upd = (total_count < MIN_FRAME_BYTES) ? total_count + 5'd1 : total_count;

    unique case (phase)
      PH_TYPE: begin
        type_bad_upd    = !(item.data_byte == snapshot_code ||
                            item.data_byte == delta_code);
        field_count_upd = 4'd0;
        phase_upd       = PH_TIME;
      end
      PH_TIME: begin
        timestamp_upd = {timestamp_shift[55:0], item.data_byte};
        if (field_count == 4'd7) begin
          field_count_upd = 4'd0;
          phase_upd       = PH_KLEN;
        end else begin
          field_count_upd = field_count + 4'd1;
        end
      end
      PH_KLEN: begin
        key_upd = key_shifted;
        if (field_count == 4'd3) begin
          field_count_upd = 4'd0;
          phase_upd       = (key_shifted == 32'd0) ? PH_PLEN : PH_KEY;
        end else begin
          field_count_upd = field_count + 4'd1;
        end
      end
      PH_KEY: begin
        key_upd = key_dec;
        if (key_dec == 32'd0) phase_upd = PH_PLEN;
      end
      PH_PLEN: begin
        payload_upd = payload_shifted;
        if (field_count == 4'd3) begin
          field_count_upd = 4'd0;
          phase_upd       = (payload_shifted == 32'd0) ? PH_EXCESS : PH_PAY;
        end else begin
          field_count_upd = field_count + 4'd1;
        end
      end
      PH_PAY: begin
        payload_upd = payload_dec;
        if (payload_dec == 32'd0) phase_upd = PH_EXCESS;
      end
      default: begin
        excess_upd = 1'b1;
        phase_upd  = PH_EXCESS;
      end
    endcase
  end

  // outputs
  always_comb begin
    if (total_count_upd < MIN_FRAME_BYTES) begin
      status = ST_TRUNCATED;
    end else if (type_bad_upd) begin
      status = ST_BAD_TYPE;
    end else if (phase_upd <= PH_PLEN) begin
      status = ST_BAD_KEY_LEN;
    end else if (phase_upd == PH_PAY || excess_upd) begin
      status = ST_BAD_PAYLOAD;
    end else begin
      status = ST_OK;
    end

    result_next.byte_out        = item.data_byte;
    result_next.byte_role       = (phase == PH_EXCESS || phase > PH_EXCESS) ?
                                  3'(PH_EXCESS) : 3'(phase);
    result_next.frame_done      = item.end_of_frame;
    result_next.frame_status    = item.end_of_frame ? 3'(status) : 3'(ST_OK);
    result_next.timestamp_value = item.end_of_frame ? timestamp_upd : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snapshot_code <= SNAPSHOT_CODE_RESET;
      delta_code    <= DELTA_CODE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SNAPSHOT_CODE: snapshot_code <= cfg_data;
        CFG_DELTA_CODE:    delta_code    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && item.end_of_frame)) begin
      phase             <= PH_TYPE;
      field_count       <= 4'd0;
      total_count       <= 5'd0;
      key_remaining     <= 32'd0;
      payload_remaining <= 32'd0;
      timestamp_shift   <= 64'd0;
      type_bad          <= 1'b0;
      excess_seen       <= 1'b0;
    end else if (accept) begin
      phase             <= phase_upd;
      field_count       <= field_count_upd;
      total_count       <= total_count_upd;
      key_remaining     <= key_upd;
      payload_remaining <= payload_upd;
      timestamp_shift   <= timestamp_upd;
      type_bad          <= type_bad_upd;
      excess_seen       <= excess_upd;
    end
  end

  `RFP_ASSERT_NEXT(a_clear_after_last, clk, rst, accept && item.end_of_frame,
                   phase == PH_TYPE && total_count == 5'd0 && timestamp_shift == 64'd0)
  `RFP_ASSERT_IMPLY(a_total_capped, clk, rst, 1'b1, total_count <= MIN_FRAME_BYTES)
  `RFP_ASSERT_IMPLY(a_key_nonzero, clk, rst, phase == PH_KEY, key_remaining != 32'd0)
  `RFP_ASSERT_IMPLY(a_pay_nonzero, clk, rst, phase == PH_PAY, payload_remaining != 32'd0)

endmodule

// ===== design/rfp_result_reg.sv =====
// Result register between the frame tracker and the result channel.
// Depends on rfp_pkg and record_frame_parser_defines.svh.
`include "record_frame_parser_defines.svh"

module rfp_result_reg
  import rfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t result_next,
  input  logic      result_ready,
  output logic      result_valid,
  output logic      load_ready,
  output out_item_t result
);

  // accepts a new item when no result is held or the held result leaves in the same cycle
  assign load_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

  `RFP_ASSERT_NEXT(a_load_shows, clk, rst, load, result_valid)
  `RFP_ASSERT_IMPLY(a_status_only_done, clk, rst, result_valid && !result.frame_done,
                    result.frame_status == 3'(ST_OK) && result.timestamp_value == 64'd0)

endmodule

// ===== design/record_frame_parser.sv =====
// Record frame parser: top level joining the frame tracker and result register.
// Depends on rfp_pkg, rfp_frame and rfp_result_reg.
//
// Usage:
//   item channel   (item_valid/item_ready/item): one frame byte per
//     transaction, end_of_frame set on the final byte.
//   result channel (result_valid/result_ready/result): one result per byte,
//     the byte passed through with its role; on the final byte frame_done is
//     set and frame_status and timestamp_value carry the frame outcome.
//   cfg channel    (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the
//     snapshot (index 0) and delta (index 1) type codes; always ready.
// Result: registered; a result appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while results are taken; all per-byte work is one
//   pass of counter updates and compares between the tracker state and the result register.
// Stall: while a result waits and result_ready is low, item_ready drops;
//   it rises again in the cycle the result is taken.
// Reset: clears the frame state and the result valid flag and restores the
//   type codes to 0 and 1. After a final byte the frame state clears itself.
module record_frame_parser
  import rfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  in_item_t             item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output out_item_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic      accept;
  out_item_t result_next;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && item_ready;

  rfp_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result_next (result_next)
  );

  rfp_result_reg u_result (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .result_next  (result_next),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .load_ready   (item_ready),
    .result       (result)
  );

endmodule
